FILE: rtl/core/bcs_pkg.sv
// Shared types and constants of the blink-code sequencer.
package bcs_pkg;

	localparam int TICK_W     = 12;
	localparam int DUR_W      = 13;
	localparam int RC_W       = 3;
	localparam int CODE_W     = 32;
	localparam int CODE_IDX_W = 5;
	localparam int LEN_IN_W   = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int COL_W      = 2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_PRE,
		PH_ON,
		PH_TRAIL,
		PH_BETWEEN
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_ON,
		CFG_LONG_ON,
		CFG_SHORT_GAP,
		CFG_LONG_GAP,
		CFG_REPEAT_GAP,
		CFG_LEAD_GAP,
		CFG_REPEAT_COUNT
	} cfg_idx_t;

	localparam logic [COL_W-1:0] COL_OFF   = 2'd0;
	localparam logic [COL_W-1:0] COL_RED   = 2'd1;
	localparam logic [COL_W-1:0] COL_WHITE = 2'd2;

	localparam logic FUNC_START = 1'b1;

	localparam logic [TICK_W-1:0] RST_SHORT_ON   = 12'd100;
	localparam logic [TICK_W-1:0] RST_LONG_ON    = 12'd400;
	localparam logic [TICK_W-1:0] RST_SHORT_GAP  = 12'd200;
	localparam logic [TICK_W-1:0] RST_LONG_GAP   = 12'd50;
	localparam logic [TICK_W-1:0] RST_REPEAT_GAP = 12'd1500;
	localparam logic [TICK_W-1:0] RST_LEAD_GAP   = 12'd500;
	localparam logic [RC_W-1:0]   RST_REPEAT_CNT = 3'd3;

	typedef struct packed {
		logic [TICK_W-1:0] short_on;
		logic [TICK_W-1:0] long_on;
		logic [TICK_W-1:0] short_gap;
		logic [TICK_W-1:0] long_gap;
		logic [TICK_W-1:0] repeat_gap;
		logic [TICK_W-1:0] lead_gap;
		logic [RC_W-1:0]   repeat_count;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] led_colour;
		logic             busy_res;
		logic             finished;
	} res_t;

endpackage

FILE: rtl/core/bcs_cfg_regs.sv
// Timing and repeat configuration registers of the blink-code sequencer.
module bcs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bcs_pkg::TICK_W-1:0]     cfg_wdata,
	output bcs_pkg::cfg_t                  cfg
);

	bcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_on     <= bcs_pkg::RST_SHORT_ON;
			cfg_q.long_on      <= bcs_pkg::RST_LONG_ON;
			cfg_q.short_gap    <= bcs_pkg::RST_SHORT_GAP;
			cfg_q.long_gap     <= bcs_pkg::RST_LONG_GAP;
			cfg_q.repeat_gap   <= bcs_pkg::RST_REPEAT_GAP;
			cfg_q.lead_gap     <= bcs_pkg::RST_LEAD_GAP;
			cfg_q.repeat_count <= bcs_pkg::RST_REPEAT_CNT;
		end else if (cfg_we) begin
			unique case (bcs_pkg::cfg_idx_t'(cfg_idx))
				bcs_pkg::CFG_SHORT_ON:     cfg_q.short_on   <= cfg_wdata;
				bcs_pkg::CFG_LONG_ON:      cfg_q.long_on    <= cfg_wdata;
				bcs_pkg::CFG_SHORT_GAP:    cfg_q.short_gap  <= cfg_wdata;
				bcs_pkg::CFG_LONG_GAP:     cfg_q.long_gap   <= cfg_wdata;
				bcs_pkg::CFG_REPEAT_GAP:   cfg_q.repeat_gap <= cfg_wdata;
				bcs_pkg::CFG_LEAD_GAP:     cfg_q.lead_gap   <= cfg_wdata;
				bcs_pkg::CFG_REPEAT_COUNT: begin
					cfg_q.repeat_count <= cfg_wdata[bcs_pkg::RC_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bcs_seq.sv
// Pattern state and combinational next-state logic, including zero-length segment skipping.
module bcs_seq #(
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          func,
	input  logic [bcs_pkg::CODE_W-1:0]    code_value,
	input  logic [bcs_pkg::LEN_IN_W-1:0]  code_length,
	input  bcs_pkg::cfg_t                 cfg,
	output bcs_pkg::res_t                 res
);

	localparam int BIT_W = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
	localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

	bcs_pkg::phase_t                 phase_q, ph_n;
	logic [bcs_pkg::DUR_W-1:0]       tick_q, tick_n;
	logic [BIT_W-1:0]                bit_q, bit_n;
	logic [bcs_pkg::RC_W-1:0]        rep_q, rep_n;
	logic [MAX_CODE_BITS-1:0]        bits_q;
	logic [LEN_W-1:0]                len_q;

	logic                            start, run;
	logic [LEN_W-1:0]                new_len, use_len;
	logic [MAX_CODE_BITS-1:0]        new_bits, use_bits;
	logic [MAX_CODE_BITS-1:0]        ne, ne_after, gap_nz;
	logic                            ne0, ne1, any_ne, next_ok;
	logic [BIT_W-1:0]                first_idx, next_idx;
	bcs_pkg::phase_t                 first_ph, next_ph;
	logic [bcs_pkg::RC_W-1:0]        rc_eff, r_base, rep_inc;
	logic                            last_rep_base, last_rep_inc, last_bit, trail_ok;
	logic                            cur_b, white;
	logic [bcs_pkg::DUR_W-1:0]       gap_cur, on_cur, dur, tick_inc;
	logic                            seg_done;

	assign start = accept && (func == bcs_pkg::FUNC_START) && (phase_q == bcs_pkg::PH_IDLE);
	assign run   = accept && (func != bcs_pkg::FUNC_START) && (phase_q != bcs_pkg::PH_IDLE);

	// Left-align the code in sending order: position k holds the k-th bit shown.
	always_comb begin
		int idx;
		idx = 0;
		if (int'(code_length) > MAX_CODE_BITS)
			new_len = LEN_W'(MAX_CODE_BITS);
		else
			new_len = LEN_W'(code_length);
		for (int k = 0; k < MAX_CODE_BITS; k++) begin
			idx = int'(new_len) - 1 - k;
			if (idx >= 0 && idx < bcs_pkg::CODE_W)
				new_bits[k] = code_value[idx[bcs_pkg::CODE_IDX_W-1:0]];
			else
				new_bits[k] = 1'b0;
		end
	end

	assign use_bits = start ? new_bits : bits_q;
	assign use_len  = start ? new_len  : len_q;

	// A bit value whose gap and on time are both zero produces no ticks at all.
	assign ne0 = (cfg.short_gap != '0) || (cfg.short_on != '0);
	assign ne1 = (cfg.long_gap  != '0) || (cfg.long_on  != '0);

	always_comb begin
		for (int k = 0; k < MAX_CODE_BITS; k++) begin
			ne[k]       = (LEN_W'(k) < use_len) && (use_bits[k] ? ne1 : ne0);
			ne_after[k] = ne[k] && (BIT_W'(k) > bit_q);
			gap_nz[k]   = use_bits[k] ? (cfg.long_gap != '0) : (cfg.short_gap != '0);
		end
	end

	assign any_ne  = |ne;
	assign next_ok = |ne_after;

	always_comb begin
		first_idx = '0;
		next_idx  = '0;
		for (int j = MAX_CODE_BITS - 1; j >= 0; j--) begin
			if (ne[j])
				first_idx = BIT_W'(j);
			if (ne_after[j])
				next_idx = BIT_W'(j);
		end
	end

	assign first_ph = gap_nz[first_idx] ? bcs_pkg::PH_PRE : bcs_pkg::PH_ON;
	assign next_ph  = gap_nz[next_idx]  ? bcs_pkg::PH_PRE : bcs_pkg::PH_ON;

	assign rc_eff        = (cfg.repeat_count == '0) ? bcs_pkg::RC_W'(1) : cfg.repeat_count;
	assign r_base        = start ? '0 : rep_q;
	assign rep_inc       = r_base + bcs_pkg::RC_W'(1);
	assign last_rep_base = r_base  >= (rc_eff - bcs_pkg::RC_W'(1));
	assign last_rep_inc  = rep_inc >= (rc_eff - bcs_pkg::RC_W'(1));
	assign last_bit      = (LEN_W'(bit_q) + LEN_W'(1)) >= len_q;
	assign trail_ok      = !(last_bit && last_rep_base);

	assign cur_b   = bits_q[bit_q];
	assign white   = (len_q == LEN_W'(1)) && !cur_b;
	assign gap_cur = {1'b0, cur_b ? cfg.long_gap : cfg.short_gap};
	assign on_cur  = cur_b ? {1'b0, cfg.long_on}
	               : (white ? {cfg.short_on, 1'b0} : {1'b0, cfg.short_on});

	always_comb begin
		unique case (phase_q)
			bcs_pkg::PH_LEAD:    dur = {1'b0, cfg.lead_gap};
			bcs_pkg::PH_PRE:     dur = gap_cur;
			bcs_pkg::PH_ON:      dur = on_cur;
			bcs_pkg::PH_TRAIL:   dur = gap_cur;
			bcs_pkg::PH_BETWEEN: dur = {1'b0, cfg.repeat_gap};
			default:             dur = '0;
		endcase
	end

	assign tick_inc = tick_q + bcs_pkg::DUR_W'(1);
	assign seg_done = tick_inc >= dur;

	// Next state: each candidate resolves straight to the next segment with a nonzero length.
	always_comb begin
		bcs_pkg::phase_t          eor_ph, srch_ph, ab_ph;
		logic [BIT_W-1:0]         eor_bit, srch_bit, ab_bit;
		logic [bcs_pkg::RC_W-1:0] eor_rep, srch_rep, ab_rep;

		// end of one pass over the code
		eor_bit = bit_q;
		eor_rep = r_base;
		priority if (last_rep_base) begin
			eor_ph = bcs_pkg::PH_IDLE;
		end else if (cfg.repeat_gap != '0) begin
			eor_ph = bcs_pkg::PH_BETWEEN;
		end else if (use_len == LEN_W'(1)) begin
			eor_ph = bcs_pkg::PH_IDLE;
		end else if (any_ne) begin
			eor_ph  = first_ph;
			eor_bit = first_idx;
			eor_rep = rep_inc;
		end else begin
			eor_ph = bcs_pkg::PH_IDLE;
		end

		// search from the first bit of the current pass
		if (any_ne) begin
			srch_ph  = first_ph;
			srch_bit = first_idx;
			srch_rep = r_base;
		end else begin
			srch_ph  = eor_ph;
			srch_bit = eor_bit;
			srch_rep = eor_rep;
		end

		// after the current bit is done
		if (next_ok) begin
			ab_ph  = next_ph;
			ab_bit = next_idx;
			ab_rep = rep_q;
		end else begin
			ab_ph  = eor_ph;
			ab_bit = eor_bit;
			ab_rep = eor_rep;
		end

		ph_n   = phase_q;
		bit_n  = bit_q;
		rep_n  = rep_q;
		tick_n = tick_q;

		if (start) begin
			tick_n = '0;
			bit_n  = '0;
			rep_n  = '0;
			priority if ((use_len != LEN_W'(1)) && (cfg.lead_gap != '0)) begin
				ph_n = bcs_pkg::PH_LEAD;
			end else if (use_len == '0) begin
				ph_n = bcs_pkg::PH_IDLE;
			end else begin
				ph_n  = srch_ph;
				bit_n = srch_bit;
				rep_n = srch_rep;
			end
		end else if (run) begin
			tick_n = tick_inc;
			if (seg_done) begin
				tick_n = '0;
				unique case (phase_q)
					bcs_pkg::PH_LEAD: begin
						if (use_len == '0) begin
							ph_n = bcs_pkg::PH_IDLE;
						end else begin
							ph_n  = srch_ph;
							bit_n = srch_bit;
							rep_n = srch_rep;
						end
					end
					bcs_pkg::PH_PRE: begin
						priority if (on_cur != '0) begin
							ph_n = bcs_pkg::PH_ON;
						end else if (trail_ok) begin
							ph_n = bcs_pkg::PH_TRAIL;
						end else begin
							ph_n  = ab_ph;
							bit_n = ab_bit;
							rep_n = ab_rep;
						end
					end
					bcs_pkg::PH_ON: begin
						if (trail_ok && (gap_cur != '0)) begin
							ph_n = bcs_pkg::PH_TRAIL;
						end else begin
							ph_n  = ab_ph;
							bit_n = ab_bit;
							rep_n = ab_rep;
						end
					end
					bcs_pkg::PH_TRAIL: begin
						ph_n  = ab_ph;
						bit_n = ab_bit;
						rep_n = ab_rep;
					end
					bcs_pkg::PH_BETWEEN: begin
						// a one-bit code is shown only once
						priority if (use_len == LEN_W'(1)) begin
							ph_n = bcs_pkg::PH_IDLE;
						end else if (any_ne) begin
							ph_n  = first_ph;
							bit_n = first_idx;
							rep_n = rep_inc;
						end else if (!last_rep_inc) begin
							ph_n  = bcs_pkg::PH_BETWEEN;
							rep_n = rep_inc;
						end else begin
							ph_n = bcs_pkg::PH_IDLE;
						end
					end
					default: ph_n = bcs_pkg::PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		res.led_colour = bcs_pkg::COL_OFF;
		if (run && (phase_q == bcs_pkg::PH_ON))
			res.led_colour = white ? bcs_pkg::COL_WHITE : bcs_pkg::COL_RED;
		res.busy_res = (ph_n != bcs_pkg::PH_IDLE);
		res.finished = (start || run) && (ph_n == bcs_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bcs_pkg::PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			rep_q   <= '0;
		end else begin
			phase_q <= ph_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			rep_q   <= rep_n;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bits_q <= new_bits;
			len_q  <= new_len;
		end
	end

endmodule

FILE: rtl/core/bcs_res_reg.sv
// Result register between the sequencer and the result channel.
module bcs_res_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  bcs_pkg::res_t               res_d,
	input  logic                        res_stall,
	output logic                        res_valid,
	output logic [bcs_pkg::COL_W-1:0]   led_colour,
	output logic                        busy_res,
	output logic                        finished,
	output logic                        hold
);

	logic          valid_q;
	bcs_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!res_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

	// a new transfer may enter whenever the held result leaves this cycle
	assign hold       = valid_q && res_stall;
	assign res_valid  = valid_q;
	assign led_colour = res_q.led_colour;
	assign busy_res   = res_q.busy_res;
	assign finished   = res_q.finished;

endmodule

FILE: rtl/core/blink_code_sequencer.sv
// Top level of the blink-code sequencer: LED error-code pattern driven by tick items.
//
// Command channel (cmd_valid/cmd_stall): func=1 starts a code (code_value, code_length),
// func=0 is one time tick. A start while a pattern runs is ignored.
// Result channel (res_valid/res_stall): one result per command transfer, carrying the LED
// colour for that tick, whether the pattern is still running, and the end-of-pattern flag.
// Latency: the result is valid in the cycle after the command transfer.
// Throughput: one command per cycle while cmd_stall is low; all of the per-item work, including skipping
// segments of zero length, is one combinational pass from the state registers into
// the result register.
// Stall: while a result waits with res_stall high, cmd_stall is high; a command is taken
// again in the same cycle the waiting result leaves.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_idx at the next clock edge; write
// only while no pattern runs and no result is pending. Indexes past the last register are
// ignored.
// Reset: pattern idle, result channel empty, timing registers at their default values.
module blink_code_sequencer #(
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bcs_pkg::TICK_W-1:0]    cfg_wdata,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          func,
	input  logic [bcs_pkg::CODE_W-1:0]    code_value,
	input  logic [bcs_pkg::LEN_IN_W-1:0]  code_length,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [bcs_pkg::COL_W-1:0]     led_colour,
	output logic                          busy_res,
	output logic                          finished
);

	bcs_pkg::cfg_t cfg;
	bcs_pkg::res_t res_d;
	logic          accept;

	assign accept = cmd_valid && !cmd_stall;

	bcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bcs_seq #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.code_value  (code_value),
		.code_length (code_length),
		.cfg         (cfg),
		.res         (res_d)
	);

	bcs_res_reg u_res (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.res_d      (res_d),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.led_colour (led_colour),
		.busy_res   (busy_res),
		.finished   (finished),
		.hold       (cmd_stall)
	);

	a_fin_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && finished |-> !busy_res)
		else $error("finished result still reports busy");

	a_lit_in_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (led_colour != bcs_pkg::COL_OFF) |-> (busy_res || finished))
		else $error("LED lit outside a running pattern");

	a_no_take_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> cmd_stall)
		else $error("command taken while result is held");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("command transfer without a result");

endmodule
